// File: rtl/core/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types and constants of the accumulator machine core: request kinds,
// instruction opcodes, stop codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package amc_pkg;

   localparam int ADDR_WIDTH_DEF = 16;
   localparam int WORD_WIDTH     = 32;
   localparam int HALF_WIDTH     = 16;
   localparam int STATUS_WIDTH   = 3;
   localparam int SHIFT_WIDTH    = 5;

   localparam logic [HALF_WIDTH-1:0] RESET_ADDR = 16'h1111;

   // request kinds
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // configuration register indexes
   localparam logic CSR_START = 1'b0;
   localparam logic CSR_FLOOR = 1'b1;

   // instruction opcodes
   localparam logic [HALF_WIDTH-1:0] OP_BLANK = 16'd0;
   localparam logic [HALF_WIDTH-1:0] OP_LDA   = 16'd1;
   localparam logic [HALF_WIDTH-1:0] OP_STO   = 16'd2;
   localparam logic [HALF_WIDTH-1:0] OP_CLA   = 16'd3;
   localparam logic [HALF_WIDTH-1:0] OP_ADD   = 16'd4;
   localparam logic [HALF_WIDTH-1:0] OP_SUB   = 16'd5;
   localparam logic [HALF_WIDTH-1:0] OP_MUL   = 16'd6;
   localparam logic [HALF_WIDTH-1:0] OP_DIV   = 16'd7;
   localparam logic [HALF_WIDTH-1:0] OP_AND   = 16'd8;
   localparam logic [HALF_WIDTH-1:0] OP_OR    = 16'd9;
   localparam logic [HALF_WIDTH-1:0] OP_XOR   = 16'd10;
   localparam logic [HALF_WIDTH-1:0] OP_SHL   = 16'd11;
   localparam logic [HALF_WIDTH-1:0] OP_SHR   = 16'd12;
   localparam logic [HALF_WIDTH-1:0] OP_JMP   = 16'd13;
   localparam logic [HALF_WIDTH-1:0] OP_JGE   = 16'd14;
   localparam logic [HALF_WIDTH-1:0] OP_JNE   = 16'd15;
   localparam logic [HALF_WIDTH-1:0] OP_HALT  = 16'd16;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STOP_OK       = 3'd0,
      STOP_BLANK    = 3'd1,
      STOP_UNKNOWN  = 3'd2,
      STOP_PC_RANGE = 3'd3,
      STOP_DIV_ZERO = 3'd4
   } stop_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_OPER,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic execute;
      logic div_finish;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fetch_go;
      logic div_go;
      logic div_done;
   } ctrl_status_type;

endpackage

// File: rtl/core/amc_ram.sv
// ----------------------------------------------------------------------------
// amc_ram
// Generic single-port RAM with one write or read address per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module amc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      rdata_ff <= store_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/amc_div.sv
// ----------------------------------------------------------------------------
// amc_div
// Signed 32-bit divider, truncating toward zero. Restoring, one quotient bit
// per cycle on magnitudes, sign applied at the output.
// ----------------------------------------------------------------------------
module amc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [amc_pkg::WORD_WIDTH-1:0] dividend,
   input  logic [amc_pkg::WORD_WIDTH-1:0] divisor,
   output logic                           done,
   output logic [amc_pkg::WORD_WIDTH-1:0] quotient
);

   localparam int W     = amc_pkg::WORD_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       rem_sh;
   logic             fits;

   assign rem_sh = {rem_ff, quo_ff[W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         neg_in = dividend[W-1] ^ divisor[W-1];
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[W-1:0];
         quo_in  = {quo_ff[W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// File: rtl/core/amc_ctrl.sv
// ----------------------------------------------------------------------------
// amc_ctrl
// Sequencer of the accumulator machine: accept, fetch, operand read and
// execute, divide wait and one-cycle response.
// ----------------------------------------------------------------------------
module amc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  amc_pkg::ctrl_status_type status,
   output amc_pkg::ctrl_cmd_type    cmd
);

   amc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         amc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = status.fetch_go ? amc_pkg::ST_FETCH : amc_pkg::ST_RESP;
            end
         end
         amc_pkg::ST_FETCH: begin
            cmd.decode = 1'b1;
            state_in   = amc_pkg::ST_OPER;
         end
         amc_pkg::ST_OPER: begin
            cmd.execute = 1'b1;
            state_in    = status.div_go ? amc_pkg::ST_DIV : amc_pkg::ST_RESP;
         end
         amc_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = amc_pkg::ST_RESP;
            end
         end
         amc_pkg::ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = amc_pkg::ST_IDLE;
         end
         default: begin
            state_in = amc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/amc_dpath.sv
// ----------------------------------------------------------------------------
// amc_dpath
// Datapath of the accumulator machine: word memory, program counter,
// accumulator, stop flag and code, configuration registers, ALU and divider.
// ----------------------------------------------------------------------------
module amc_dpath #(
   parameter int ADDR_WIDTH = amc_pkg::ADDR_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  amc_pkg::ctrl_cmd_type            cmd,
   output amc_pkg::ctrl_status_type         status,
   input  logic [1:0]                       req_opcode,
   input  logic [amc_pkg::HALF_WIDTH-1:0]   req_mem_address,
   input  logic [amc_pkg::WORD_WIDTH-1:0]   req_mem_data,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [amc_pkg::HALF_WIDTH-1:0]   csr_wdata,
   output logic                             rsp_strobe,
   output logic [amc_pkg::HALF_WIDTH-1:0]   rsp_prog_counter,
   output logic signed [amc_pkg::WORD_WIDTH-1:0] rsp_accumulator,
   output logic [amc_pkg::HALF_WIDTH-1:0]   rsp_executed_op,
   output logic                             rsp_halted,
   output logic [amc_pkg::STATUS_WIDTH-1:0] rsp_status
);

   localparam int W = amc_pkg::WORD_WIDTH;
   localparam int H = amc_pkg::HALF_WIDTH;

   logic [H-1:0]          start_ff, floor_ff;
   logic [ADDR_WIDTH-1:0] pc_ff, pc_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic                  stopped_ff, stopped_in;
   amc_pkg::stop_code_type code_ff, code_in;
   logic [H-1:0]          exec_ff, exec_in;
   logic [W-1:0]          ir_ff, ir_in;

   logic [ADDR_WIDTH-1:0] ram_addr;
   logic                  ram_we;
   logic [W-1:0]          ram_wdata, ram_rdata;

   logic [H-1:0]          op;
   logic [ADDR_WIDTH-1:0] arg;
   logic [W-1:0]          val, mul_lo, shl_res, shr_res;
   logic                  big_shift, below_floor, write_item;
   logic                  div_done;
   logic [W-1:0]          div_quo;

   assign op          = ir_ff[W-1:H];
   assign arg         = ir_ff[ADDR_WIDTH-1:0];
   assign val         = ram_rdata;
   assign mul_lo      = W'(acc_ff * val);
   assign big_shift   = |val[W-1:amc_pkg::SHIFT_WIDTH];
   assign shl_res     = big_shift ? '0 : (acc_ff << val[amc_pkg::SHIFT_WIDTH-1:0]);
   assign shr_res     = big_shift ? {W{acc_ff[W-1]}}
                                  : W'($signed(acc_ff) >>> val[amc_pkg::SHIFT_WIDTH-1:0]);
   assign below_floor = H'(pc_ff) < floor_ff;
   assign write_item  = cmd.accept && (req_opcode == amc_pkg::KIND_WRITE);

   assign status.fetch_go = (req_opcode == amc_pkg::KIND_STEP) && !stopped_ff && !below_floor;
   assign status.div_go   = (op == amc_pkg::OP_DIV) && (val != '0);
   assign status.div_done = div_done;

   // memory port
   always_comb begin
      ram_addr  = pc_ff;
      ram_we    = 1'b0;
      ram_wdata = acc_ff;
      if (write_item) begin
         ram_addr  = req_mem_address[ADDR_WIDTH-1:0];
         ram_we    = 1'b1;
         ram_wdata = req_mem_data;
      end else if (cmd.decode) begin
         ram_addr = ram_rdata[ADDR_WIDTH-1:0];
      end else if (cmd.execute) begin
         ram_addr = arg;
         ram_we   = (op == amc_pkg::OP_STO);
      end
   end

   amc_ram #(
      .WIDTH (W),
      .DEPTH (2 ** ADDR_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   amc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.execute && status.div_go),
      .dividend (acc_ff),
      .divisor  (val),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      pc_in      = pc_ff;
      acc_in     = acc_ff;
      stopped_in = stopped_ff;
      code_in    = code_ff;
      exec_in    = exec_ff;
      ir_in      = ir_ff;
      priority if (cmd.accept) begin
         exec_in = '0;
         unique case (req_opcode)
            amc_pkg::KIND_STEP: begin
               if (!stopped_ff && below_floor) begin
                  stopped_in = 1'b1;
                  code_in    = amc_pkg::STOP_PC_RANGE;
               end
            end
            amc_pkg::KIND_RESTART: begin
               pc_in      = start_ff[ADDR_WIDTH-1:0];
               acc_in     = '0;
               stopped_in = 1'b0;
               code_in    = amc_pkg::STOP_OK;
            end
            default: begin
            end
         endcase
      end else if (cmd.decode) begin
         ir_in   = ram_rdata;
         pc_in   = pc_ff + 1'b1;
         exec_in = ram_rdata[W-1:H];
      end else if (cmd.execute) begin
         unique case (op)
            amc_pkg::OP_BLANK: begin
               stopped_in = 1'b1;
               code_in    = amc_pkg::STOP_BLANK;
            end
            amc_pkg::OP_LDA: acc_in = val;
            amc_pkg::OP_STO: begin
            end
            amc_pkg::OP_CLA: acc_in = '0;
            amc_pkg::OP_ADD: acc_in = acc_ff + val;
            amc_pkg::OP_SUB: acc_in = acc_ff - val;
            amc_pkg::OP_MUL: acc_in = mul_lo;
            amc_pkg::OP_DIV: begin
               if (val == '0) begin
                  stopped_in = 1'b1;
                  code_in    = amc_pkg::STOP_DIV_ZERO;
               end
            end
            amc_pkg::OP_AND: acc_in = acc_ff & val;
            amc_pkg::OP_OR:  acc_in = acc_ff | val;
            amc_pkg::OP_XOR: acc_in = acc_ff ^ val;
            amc_pkg::OP_SHL: acc_in = shl_res;
            amc_pkg::OP_SHR: acc_in = shr_res;
            amc_pkg::OP_JMP: pc_in = arg;
            amc_pkg::OP_JGE: begin
               if (!acc_ff[W-1]) begin
                  pc_in = arg;
               end
            end
            amc_pkg::OP_JNE: begin
               if (acc_ff != '0) begin
                  pc_in = arg;
               end
            end
            amc_pkg::OP_HALT: begin
               stopped_in = 1'b1;
               code_in    = amc_pkg::STOP_OK;
            end
            default: begin
               stopped_in = 1'b1;
               code_in    = amc_pkg::STOP_UNKNOWN;
            end
         endcase
      end else if (cmd.div_finish) begin
         acc_in = div_quo;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= amc_pkg::RESET_ADDR;
         floor_ff   <= amc_pkg::RESET_ADDR;
         pc_ff      <= amc_pkg::RESET_ADDR[ADDR_WIDTH-1:0];
         acc_ff     <= '0;
         stopped_ff <= 1'b0;
         code_ff    <= amc_pkg::STOP_OK;
         exec_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               amc_pkg::CSR_START: start_ff <= csr_wdata;
               amc_pkg::CSR_FLOOR: floor_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         pc_ff      <= pc_in;
         acc_ff     <= acc_in;
         stopped_ff <= stopped_in;
         code_ff    <= code_in;
         exec_ff    <= exec_in;
      end
      ir_ff <= ir_in;
   end

   assign rsp_strobe       = cmd.respond;
   assign rsp_prog_counter = H'(pc_ff);
   assign rsp_accumulator  = $signed(acc_ff);
   assign rsp_executed_op  = exec_ff;
   assign rsp_halted       = stopped_ff;
   assign rsp_status       = code_ff;

endmodule

// File: rtl/core/accumulator_machine_core_top.sv
// Timing: result strobe in the cycle after the accepting edge for write and
// restart beats and steps that fetch nothing; others pass the fetch and operand
// states, nonzero divides the bit-serial divider too. One beat at a time, start
// taken again the cycle after the strobe. Results show for one cycle; no stall.
// Reset: synchronous, active high; pc and both address registers to 0x1111,
// accumulator, stop flag and stop code to zero; memory undefined until written.
// ----------------------------------------------------------------------------
// accumulator_machine_core_top
// Single-accumulator machine with one word memory: controller and datapath.
// ----------------------------------------------------------------------------
module accumulator_machine_core_top #(
   parameter int ADDR_WIDTH = amc_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic [amc_pkg::HALF_WIDTH-1:0]        req_mem_address,
   input  logic [amc_pkg::WORD_WIDTH-1:0]        req_mem_data,
   input  logic                                  csr_write_en,
   input  logic                                  csr_index,
   input  logic [amc_pkg::HALF_WIDTH-1:0]        csr_wdata,
   output logic                                  rsp_strobe,
   output logic [amc_pkg::HALF_WIDTH-1:0]        rsp_prog_counter,
   output logic signed [amc_pkg::WORD_WIDTH-1:0] rsp_accumulator,
   output logic [amc_pkg::HALF_WIDTH-1:0]        rsp_executed_op,
   output logic                                  rsp_halted,
   output logic [amc_pkg::STATUS_WIDTH-1:0]      rsp_status
);

   amc_pkg::ctrl_cmd_type    cmd;
   amc_pkg::ctrl_status_type status;

   amc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   amc_dpath #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_prog_counter (rsp_prog_counter),
      .rsp_accumulator  (rsp_accumulator),
      .rsp_executed_op  (rsp_executed_op),
      .rsp_halted       (rsp_halted),
      .rsp_status       (rsp_status)
   );

endmodule

// File: verif/accumulator_machine_core_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accumulator_machine_core_top_test
// Self-checking bench for the accumulator machine core. A short directed
// sequence drives the arithmetic extremes, the stop codes other than blank and
// both address registers at their limits. Random phases follow: each phase sets
// new start and floor addresses, loads data words and a small program, then
// restarts and steps through it with noise beats mixed in. A shadow machine
// predicts each result unless a directed row gives its own, and each strobed
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module accumulator_machine_core_top_test;

   localparam int H = amc_pkg::HALF_WIDTH;
   localparam int W = amc_pkg::WORD_WIDTH;

   localparam logic [1:0] KIND_IGNORED = 2'd3;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int VECTOR_ROWS  = 25;

   typedef struct packed {
      logic [H-1:0]           pc;
      logic [W-1:0]           acc;
      logic [H-1:0]           op;
      logic                   halted;
      amc_pkg::stop_code_type status;
   } machine_view_type;

   typedef struct packed {
      logic             csr;
      logic [1:0]       kind;
      logic [H-1:0]     addr;
      logic [W-1:0]     data;
      logic             typed;
      machine_view_type want;
   } vector_row_type;

   localparam machine_view_type NO_VIEW = '{16'h0, 32'h0, 16'h0, 1'b0, amc_pkg::STOP_OK};

   // csr rows carry the register index in addr and the value in data
   localparam vector_row_type VECTORS [VECTOR_ROWS] = '{
      '{1'b0, KIND_IGNORED, 16'h5a5a, 32'ha5a5_a5a5, 1'b1,
        '{16'h1111, 32'h0, 16'h0, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h0000, 32'h8000_0000, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'hffff, 32'hffff_ffff, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h0001, 32'd32, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1111, {amc_pkg::OP_LDA, 16'h0000}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1112, {amc_pkg::OP_DIV, 16'hffff}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1113, {amc_pkg::OP_SHR, 16'h0001}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1114, {amc_pkg::OP_SHL, 16'h0001}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1115, {amc_pkg::OP_STO, 16'h0001}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_WRITE, 16'h1116, {amc_pkg::OP_DIV, 16'h0001}, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_RESTART, 16'hffff, 32'hffff_ffff, 1'b1,
        '{16'h1111, 32'h0, 16'h0, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1112, 32'h8000_0000, amc_pkg::OP_LDA, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1113, 32'h8000_0000, amc_pkg::OP_DIV, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1114, 32'hffff_ffff, amc_pkg::OP_SHR, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1115, 32'h0, amc_pkg::OP_SHL, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1116, 32'h0, amc_pkg::OP_STO, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1117, 32'h0, amc_pkg::OP_DIV, 1'b1, amc_pkg::STOP_DIV_ZERO}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1117, 32'h0, 16'h0, 1'b1, amc_pkg::STOP_DIV_ZERO}},
      '{1'b1, amc_pkg::KIND_WRITE, {15'd0, amc_pkg::CSR_FLOOR}, 32'h1112, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_RESTART, 16'h0000, 32'h0, 1'b1,
        '{16'h1111, 32'h0, 16'h0, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h1111, 32'h0, 16'h0, 1'b1, amc_pkg::STOP_PC_RANGE}},
      '{1'b1, amc_pkg::KIND_WRITE, {15'd0, amc_pkg::CSR_FLOOR}, 32'h0000, 1'b0, NO_VIEW},
      '{1'b1, amc_pkg::KIND_WRITE, {15'd0, amc_pkg::CSR_START}, 32'hffff, 1'b0, NO_VIEW},
      '{1'b0, amc_pkg::KIND_RESTART, 16'h0000, 32'h0, 1'b1,
        '{16'hffff, 32'h0, 16'h0, 1'b0, amc_pkg::STOP_OK}},
      '{1'b0, amc_pkg::KIND_STEP, 16'h0000, 32'h0, 1'b1,
        '{16'h0000, 32'h0, 16'hffff, 1'b1, amc_pkg::STOP_UNKNOWN}}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_opcode = amc_pkg::KIND_WRITE;
   logic [H-1:0]                     req_mem_address = '0;
   logic [W-1:0]                     req_mem_data = '0;
   logic                             csr_write_en = 1'b0;
   logic                             csr_index = amc_pkg::CSR_START;
   logic [H-1:0]                     csr_wdata = '0;
   logic                             rsp_strobe;
   logic [H-1:0]                     rsp_prog_counter;
   logic signed [W-1:0]              rsp_accumulator;
   logic [H-1:0]                     rsp_executed_op;
   logic                             rsp_halted;
   logic [amc_pkg::STATUS_WIDTH-1:0] rsp_status;

   // shadow machine
   logic [W-1:0]           shadow_mem [0:65535];
   bit                     shadow_written [0:65535];
   logic [H-1:0]           mach_pc = amc_pkg::RESET_ADDR;
   logic [W-1:0]           mach_acc = '0;
   bit                     mach_stopped = 1'b0;
   amc_pkg::stop_code_type mach_code = amc_pkg::STOP_OK;
   logic [H-1:0]           reg_start = amc_pkg::RESET_ADDR;
   logic [H-1:0]           reg_floor = amc_pkg::RESET_ADDR;

   machine_view_type pending_views [$];
   logic [H-1:0]     data_addrs [4];
   logic [H-1:0]     prog_base = amc_pkg::RESET_ADDR;
   int               prog_span = 1;
   bit               calm_phase = 1'b0;

   int cycle_count = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int fetch_count = 0;
   int stop_count = 0;
   int phase_count = 0;
   int mismatch_count = 0;

   accumulator_machine_core_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_prog_counter (rsp_prog_counter),
      .rsp_accumulator  (rsp_accumulator),
      .rsp_executed_op  (rsp_executed_op),
      .rsp_halted       (rsp_halted),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic machine_view_type advance_machine(input logic [1:0] kind,
                                                        input logic [H-1:0] addr,
                                                        input logic [W-1:0] data);
      machine_view_type    view;
      logic [W-1:0]        word, val, mag_a, mag_b, quot;
      logic signed [W-1:0] sacc;
      logic [H-1:0]        op, arg;
      op = '0;
      case (kind)
         amc_pkg::KIND_WRITE: begin
            shadow_mem[addr] = data;
            shadow_written[addr] = 1'b1;
         end
         amc_pkg::KIND_STEP: begin
            if (!mach_stopped && mach_pc < reg_floor) begin
               mach_stopped = 1'b1;
               mach_code = amc_pkg::STOP_PC_RANGE;
               stop_count++;
            end else if (!mach_stopped) begin
               word = shadow_mem[mach_pc];
               mach_pc = mach_pc + 16'd1;
               op = word[31:16];
               arg = word[15:0];
               val = shadow_mem[arg];
               fetch_count++;
               case (op)
                  amc_pkg::OP_BLANK: begin
                     mach_stopped = 1'b1;
                     mach_code = amc_pkg::STOP_BLANK;
                  end
                  amc_pkg::OP_LDA: mach_acc = val;
                  amc_pkg::OP_STO: begin
                     shadow_mem[arg] = mach_acc;
                     shadow_written[arg] = 1'b1;
                  end
                  amc_pkg::OP_CLA: mach_acc = '0;
                  amc_pkg::OP_ADD: mach_acc = mach_acc + val;
                  amc_pkg::OP_SUB: mach_acc = mach_acc - val;
                  amc_pkg::OP_MUL: mach_acc = mach_acc * val;
                  amc_pkg::OP_DIV: begin
                     if (val == '0) begin
                        mach_stopped = 1'b1;
                        mach_code = amc_pkg::STOP_DIV_ZERO;
                     end else begin
                        mag_a = mach_acc[31] ? (32'd0 - mach_acc) : mach_acc;
                        mag_b = val[31] ? (32'd0 - val) : val;
                        quot = mag_a / mag_b;
                        mach_acc = (mach_acc[31] ^ val[31]) ? (32'd0 - quot) : quot;
                     end
                  end
                  amc_pkg::OP_AND: mach_acc = mach_acc & val;
                  amc_pkg::OP_OR:  mach_acc = mach_acc | val;
                  amc_pkg::OP_XOR: mach_acc = mach_acc ^ val;
                  amc_pkg::OP_SHL: begin
                     if (val >= 32) mach_acc = '0;
                     else mach_acc = mach_acc << val[4:0];
                  end
                  amc_pkg::OP_SHR: begin
                     sacc = mach_acc;
                     if (val >= 32) mach_acc = {32{mach_acc[31]}};
                     else mach_acc = sacc >>> val[4:0];
                  end
                  amc_pkg::OP_JMP: mach_pc = arg;
                  amc_pkg::OP_JGE: if (!mach_acc[31]) mach_pc = arg;
                  amc_pkg::OP_JNE: if (mach_acc != '0) mach_pc = arg;
                  amc_pkg::OP_HALT: begin
                     mach_stopped = 1'b1;
                     mach_code = amc_pkg::STOP_OK;
                  end
                  default: begin
                     mach_stopped = 1'b1;
                     mach_code = amc_pkg::STOP_UNKNOWN;
                  end
               endcase
               if (mach_stopped) stop_count++;
            end
         end
         amc_pkg::KIND_RESTART: begin
            mach_pc = reg_start;
            mach_acc = '0;
            mach_stopped = 1'b0;
            mach_code = amc_pkg::STOP_OK;
         end
         default: ;
      endcase
      view.pc = mach_pc;
      view.acc = mach_acc;
      view.op = op;
      view.halted = mach_stopped;
      view.status = mach_code;
      return view;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [W-1:0] random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return $urandom_range(0, 40);
      if (r < 22) return 32'h0;
      if (r < 26) return 32'h8000_0000;
      if (r < 30) return 32'h7fff_ffff;
      if (r < 35) return 32'hffff_ffff;
      return $urandom;
   endfunction

   function automatic logic [W-1:0] random_instruction();
      logic [H-1:0] op, arg;
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) op = amc_pkg::OP_BLANK;
      else if (r < 8) op = 16'($urandom_range(amc_pkg::OP_HALT + 1, 16'hffff));
      else if (r < 12) op = amc_pkg::OP_HALT;
      else op = 16'($urandom_range(amc_pkg::OP_LDA, amc_pkg::OP_JNE));
      if (op == amc_pkg::OP_JMP || op == amc_pkg::OP_JGE || op == amc_pkg::OP_JNE)
         arg = 16'(prog_base + $urandom_range(0, prog_span - 1));
      else
         arg = data_addrs[2'($urandom_range(0, 3))];
      return {op, arg};
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [W-1:0] got,
                              input logic [W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %h want %h",
                                   beats_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      machine_view_type want;
      if (!reset && rsp_strobe) begin
         if (pending_views.size() == 0) begin
            report_mismatch("result strobed with nothing pending");
         end else begin
            want = pending_views.pop_front();
            check_field("prog_counter", 32'(rsp_prog_counter), 32'(want.pc));
            check_field("accumulator", rsp_accumulator, want.acc);
            check_field("executed_op", 32'(rsp_executed_op), 32'(want.op));
            check_field("halted", 32'(rsp_halted), 32'(want.halted));
            check_field("status", 32'(rsp_status), 32'(want.status));
         end
         beats_checked++;
      end
   end

   task automatic drive_beat(input logic [1:0] kind, input logic [H-1:0] addr,
                             input logic [W-1:0] data, input bit typed,
                             input machine_view_type typed_view);
      int               gap;
      machine_view_type view;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_opcode = kind;
      req_mem_address = addr;
      req_mem_data = data;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      view = advance_machine(kind, addr, data);
      pending_views.push_back(typed ? typed_view : view);
      if (kind != KIND_IGNORED) items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending_views.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [H-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (index == amc_pkg::CSR_START) reg_start = value;
      else reg_floor = value;
   endtask

   // back the fetch and its operand with written words
   task automatic prime_step();
      logic [W-1:0] word;
      if (!mach_stopped && mach_pc >= reg_floor) begin
         if (!shadow_written[mach_pc])
            drive_beat(amc_pkg::KIND_WRITE, mach_pc, random_instruction(), 1'b0, NO_VIEW);
         word = shadow_mem[mach_pc];
         if (!shadow_written[word[15:0]])
            drive_beat(amc_pkg::KIND_WRITE, word[15:0], random_word(), 1'b0, NO_VIEW);
      end
   endtask

   initial begin
      int             i, step_idx, r, step_total, item_target;
      logic [H-1:0]   start_val, floor_val;
      vector_row_type row;

      foreach (data_addrs[k]) data_addrs[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < VECTOR_ROWS; i++) begin
         row = VECTORS[i];
         if (row.csr) begin
            wait_idle();
            write_csr(row.addr[0], row.data[15:0]);
         end else begin
            drive_beat(row.kind, row.addr, row.data, row.typed, row.want);
         end
      end

      item_target = items_sent + RANDOM_ITEMS;
      while (items_sent < item_target) begin
         wait_idle();
         r = $urandom_range(0, 9);
         if (r < 2) start_val = 16'h0000;
         else if (r < 4) start_val = 16'hffff;
         else start_val = 16'($urandom);
         r = $urandom_range(0, 9);
         if (r < 2) floor_val = 16'h0000;
         else if (r == 2) floor_val = 16'hffff;
         else if (r == 3) floor_val = 16'(start_val + $urandom_range(1, 50));
         else floor_val = 16'($urandom_range(0, start_val));
         write_csr(amc_pkg::CSR_START, start_val);
         write_csr(amc_pkg::CSR_FLOOR, floor_val);
         phase_count++;
         calm_phase = ($urandom_range(0, 4) == 0);

         for (i = 0; i < 4; i++) begin
            data_addrs[i] = 16'($urandom);
            drive_beat(amc_pkg::KIND_WRITE, data_addrs[i], random_word(), 1'b0, NO_VIEW);
         end
         prog_base = reg_start;
         prog_span = $urandom_range(3, 12);
         for (i = 0; i < prog_span; i++) begin
            if (i == prog_span - 1 && $urandom_range(0, 9) < 7)
               drive_beat(amc_pkg::KIND_WRITE, 16'(prog_base + i),
                          {amc_pkg::OP_HALT, data_addrs[0]}, 1'b0, NO_VIEW);
            else
               drive_beat(amc_pkg::KIND_WRITE, 16'(prog_base + i), random_instruction(),
                          1'b0, NO_VIEW);
         end
         drive_beat(amc_pkg::KIND_RESTART, 16'($urandom), $urandom, 1'b0, NO_VIEW);

         step_total = $urandom_range(prog_span, 2 * prog_span + 6);
         for (step_idx = 0; step_idx < step_total; step_idx++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               drive_beat(amc_pkg::KIND_WRITE, 16'($urandom), $urandom, 1'b0, NO_VIEW);
            else if (r < 6)
               drive_beat(KIND_IGNORED, 16'($urandom), $urandom, 1'b0, NO_VIEW);
            else if (r < 8 || (mach_stopped && r < 40))
               drive_beat(amc_pkg::KIND_RESTART, 16'($urandom), $urandom, 1'b0, NO_VIEW);
            prime_step();
            drive_beat(amc_pkg::KIND_STEP, 16'($urandom), $urandom, 1'b0, NO_VIEW);
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("Run covered %0d beats over %0d register settings after the directed rows.",
               beats_checked, phase_count);
      $display("Shadow machine fetched %0d instructions and stopped %0d times.",
               fetch_count, stop_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d results pending.",
               cycle_count, pending_views.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
rtl/core/amc_pkg.sv
rtl/core/amc_ram.sv
rtl/core/amc_div.sv
rtl/core/amc_ctrl.sv
rtl/core/amc_dpath.sv
rtl/core/accumulator_machine_core_top.sv
verif/accumulator_machine_core_top_test.sv
